// File: rtl/core/lsic_pkg.sv
// Shared widths, register codes and types for the lane segment intercept classifier.
`timescale 1ns / 1ps
`default_nettype none

package lsic_pkg;

    // Pixel coordinates and the configuration fields.
    localparam int COORD_W = 10;
    localparam int SLOPE_W = 4;

    // Signed endpoint difference, one bit wider than a coordinate.
    localparam int DIFF_W  = COORD_W + 1;

    // Each partial product of the intercept numerator, and their sum, fit in
    // 22 signed bits, so the numerator magnitude takes 21 bits.
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int MAG_W   = PROD_W - 1;

    // Width used to saturate against any result width up to 32 bits.
    localparam int EXT_W   = 33;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_REFERENCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_LIMIT = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [COORD_W-1:0] Y_REFERENCE_RST = 10'd400;
    localparam logic [SLOPE_W-1:0] SLOPE_LIMIT_RST = 4'd5;

    // Status that the divider reports to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

// File: rtl/core/lsic_div.sv
// Bit-serial restoring divider for the intercept magnitude, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module lsic_div
    import lsic_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [MAG_W-1:0]   i_dividend,
    input  wire logic [COORD_W-1:0] i_divisor,
    output t_div_stat               o_stat,
    output logic [MAG_W-1:0]        o_quot
);

    localparam int CNT_W = $clog2(MAG_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAG_W - 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [MAG_W-1:0]   r_q;
    logic [COORD_W-1:0] r_rem;
    logic [COORD_W-1:0] r_div;

    logic [COORD_W:0]   w_rem_sh;
    logic               w_ge;
    logic [COORD_W:0]   w_diff;
    logic [COORD_W-1:0] n_rem;

    // The quotient register doubles as the dividend shifter: dividend bits
    // leave at the top while quotient bits enter at the bottom.
    always_comb begin
        w_rem_sh = {r_rem, r_q[MAG_W-1]};
        w_ge     = (w_rem_sh >= {1'b0, r_div});
        w_diff   = w_rem_sh - {1'b0, r_div};
        n_rem    = w_ge ? w_diff[COORD_W-1:0] : w_rem_sh[COORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[MAG_W-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_q;

endmodule

`default_nettype wire

// File: rtl/core/lane_segment_intercept_classifier_top.sv
// Top level of the lane segment intercept classifier: sequencer, tracking and output register.
`timescale 1ns / 1ps
`default_nettype none
// A kept segment word passes, after acceptance, through the setup states S_PREP and S_NUM,
// the divide state S_DIV (21 quotient bits, then the divider's done strobe), S_UPD to track
// and S_EMIT to finish. No new word is taken until the block is back in idle; markers and
// rejected segments skip the divider. The frame result enters the output register at the
// finishing edge; a waiting result stalls only a later last word.
// Reset is synchronous, active low: y_reference 400, slope_limit 5, all tracking cleared.

module lane_segment_intercept_classifier_top
    import lsic_pkg::*;
#(
    parameter int RESULT_BITS = 20
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [COORD_W-1:0]     i_cfg_data,

    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [COORD_W-1:0]     i_x_start,
    input  wire logic [COORD_W-1:0]     i_y_start,
    input  wire logic [COORD_W-1:0]     i_x_end,
    input  wire logic [COORD_W-1:0]     i_y_end,
    input  wire logic                   i_has_segment,
    input  wire logic                   i_last_of_frame,

    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic signed [RESULT_BITS-1:0] o_left_min_x,
    output logic signed [RESULT_BITS-1:0] o_left_max_x,
    output logic signed [RESULT_BITS-1:0] o_right_min_x,
    output logic signed [RESULT_BITS-1:0] o_right_max_x,
    output logic                        o_left_found,
    output logic                        o_right_found
);

    // Saturation bounds of the signed result range.
    localparam longint SAT_HI_L = (64'sd1 <<< (RESULT_BITS - 1)) - 64'sd1;
    localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'(SAT_HI_L);
    localparam logic signed [EXT_W-1:0] SAT_LO = EXT_W'(-SAT_HI_L - 64'sd1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_NUM  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Configuration registers.
    logic [COORD_W-1:0] r_y_ref;
    logic [SLOPE_W-1:0] r_slope;

    // Captured input word.
    logic [COORD_W-1:0] r_xs;
    logic [COORD_W-1:0] r_ys;
    logic [COORD_W-1:0] r_xe;
    logic [COORD_W-1:0] r_ye;
    logic               r_has;
    logic               r_last;

    // Setup results.
    logic signed [PROD_W-1:0] r_p0;
    logic signed [PROD_W-1:0] r_p1;
    logic                     r_left;
    logic                     r_dy_neg;
    logic [COORD_W-1:0]       r_ady;
    logic                     r_q_neg;

    // Per-side tracking state.
    logic                          r_left_seen;
    logic                          r_right_seen;
    logic signed [RESULT_BITS-1:0] r_left_lo;
    logic signed [RESULT_BITS-1:0] r_left_hi;
    logic signed [RESULT_BITS-1:0] r_right_lo;
    logic signed [RESULT_BITS-1:0] r_right_hi;

    // Output register.
    logic                          r_out_valid;
    logic signed [RESULT_BITS-1:0] r_out_lmin;
    logic signed [RESULT_BITS-1:0] r_out_lmax;
    logic signed [RESULT_BITS-1:0] r_out_rmin;
    logic signed [RESULT_BITS-1:0] r_out_rmax;
    logic                          r_out_lf;
    logic                          r_out_rf;

    // Combinational helpers.
    logic                     w_accept;
    logic signed [DIFF_W-1:0] w_dx;
    logic signed [DIFF_W-1:0] w_dy;
    logic signed [DIFF_W-1:0] w_dyref;
    logic [COORD_W-1:0]       w_adx;
    logic [COORD_W-1:0]       w_ady;
    logic [COORD_W+SLOPE_W-1:0] w_lim_adx;
    logic                     w_kept;
    logic                     w_go;
    logic signed [PROD_W-1:0] w_num;
    logic [MAG_W-1:0]         w_num_abs;
    logic                     w_div_start;
    t_div_stat                w_div_stat;
    logic [MAG_W-1:0]         w_quot;
    logic signed [PROD_W-1:0] w_val;
    logic signed [EXT_W-1:0]  w_val_ext;
    logic signed [EXT_W-1:0]  w_sat;
    logic signed [RESULT_BITS-1:0] w_x;
    logic                     w_out_free;
    logic                     w_load_out;

    assign w_accept = i_valid && o_ready;
    assign o_ready  = (r_state == S_IDLE);

    // Configuration writes; the index field covers exactly the two registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_ref <= Y_REFERENCE_RST;
            r_slope <= SLOPE_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_Y_REFERENCE: r_y_ref <= i_cfg_data;
                CFG_SLOPE_LIMIT: r_slope <= i_cfg_data[SLOPE_W-1:0];
                default: ;
            endcase
        end
    end

    // Slope test and the two partial products of the intercept numerator,
    // x_start*dy + (y_reference - y_start)*dx.
    always_comb begin
        w_dx      = $signed({1'b0, r_xe}) - $signed({1'b0, r_xs});
        w_dy      = $signed({1'b0, r_ye}) - $signed({1'b0, r_ys});
        w_dyref   = $signed({1'b0, r_y_ref}) - $signed({1'b0, r_ys});
        w_adx     = w_dx[DIFF_W-1] ? COORD_W'(-w_dx) : w_dx[COORD_W-1:0];
        w_ady     = w_dy[DIFF_W-1] ? COORD_W'(-w_dy) : w_dy[COORD_W-1:0];
        w_lim_adx = r_slope * w_adx;
        // A slope exactly at the limit is kept only for a rightward segment.
        w_kept    = ({{SLOPE_W{1'b0}}, w_ady} < w_lim_adx) ||
                    (!w_dx[DIFF_W-1] && (w_adx != '0) &&
                     ({{SLOPE_W{1'b0}}, w_ady} == w_lim_adx));
        w_go      = r_has && w_kept && (w_dy != '0);
    end

    // Numerator sum and its magnitude for the divider.
    always_comb begin
        w_num     = r_p0 + r_p1;
        w_num_abs = w_num[PROD_W-1] ? MAG_W'(-w_num) : w_num[MAG_W-1:0];
    end

    assign w_div_start = (r_state == S_NUM);

    lsic_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_num_abs),
        .i_divisor  (r_ady),
        .o_stat     (w_div_stat),
        .o_quot     (w_quot)
    );

    // Signed quotient, truncated toward zero, then saturated to the result range.
    always_comb begin
        w_val     = r_q_neg ? -$signed({1'b0, w_quot}) : $signed({1'b0, w_quot});
        w_val_ext = EXT_W'(w_val);
        if (w_val_ext > SAT_HI) begin
            w_sat = SAT_HI;
        end else if (w_val_ext < SAT_LO) begin
            w_sat = SAT_LO;
        end else begin
            w_sat = w_val_ext;
        end
        w_x = w_sat[RESULT_BITS-1:0];
    end

    assign w_out_free = !r_out_valid || i_ready;
    assign w_load_out = (r_state == S_EMIT) && r_last && w_out_free;

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = w_go ? S_NUM : S_EMIT;
            end
            S_NUM: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_last || w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers of the word in flight.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_xs   <= i_x_start;
            r_ys   <= i_y_start;
            r_xe   <= i_x_end;
            r_ye   <= i_y_end;
            r_has  <= i_has_segment;
            r_last <= i_last_of_frame;
        end
        if (r_state == S_PREP) begin
            r_p0     <= w_dyref * w_dx;
            r_p1     <= $signed({1'b0, r_xs}) * w_dy;
            r_left   <= w_dx[DIFF_W-1] ^ w_dy[DIFF_W-1];
            r_dy_neg <= w_dy[DIFF_W-1];
            r_ady    <= w_ady;
        end
        if (r_state == S_NUM) begin
            r_q_neg <= w_num[PROD_W-1] ^ r_dy_neg;
        end
    end

    // Per-side minimum and maximum; the first segment of a side seeds both.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_load_out) begin
            r_left_seen  <= 1'b0;
            r_right_seen <= 1'b0;
            r_left_lo    <= '0;
            r_left_hi    <= '0;
            r_right_lo   <= '0;
            r_right_hi   <= '0;
        end else if (r_state == S_UPD) begin
            if (r_left) begin
                r_left_seen <= 1'b1;
                if (!r_left_seen || (w_x < r_left_lo)) begin
                    r_left_lo <= w_x;
                end
                if (!r_left_seen || (w_x > r_left_hi)) begin
                    r_left_hi <= w_x;
                end
            end else begin
                r_right_seen <= 1'b1;
                if (!r_right_seen || (w_x < r_right_lo)) begin
                    r_right_lo <= w_x;
                end
                if (!r_right_seen || (w_x > r_right_hi)) begin
                    r_right_hi <= w_x;
                end
            end
        end
    end

    // Output register. Sides without a segment still hold zero from the clear.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_lmin <= r_left_lo;
            r_out_lmax <= r_left_hi;
            r_out_rmin <= r_right_lo;
            r_out_rmax <= r_right_hi;
            r_out_lf   <= r_left_seen;
            r_out_rf   <= r_right_seen;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_left_min_x  = r_out_lmin;
    assign o_left_max_x  = r_out_lmax;
    assign o_right_min_x = r_out_rmin;
    assign o_right_max_x = r_out_rmax;
    assign o_left_found  = r_out_lf;
    assign o_right_found = r_out_rf;

    // The divider runs and finishes only while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_stat.busy || w_div_stat.done) |-> (r_state == S_DIV))
        else $error("divider active outside the divide state");

    // Setup starts only after a word was taken.
    a_prep_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PREP) |-> $past(i_valid && o_ready))
        else $error("setup entered without an accepted word");

    // Emitting a frame result clears both sides.
    a_clear_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> (!r_left_seen && !r_right_seen && o_valid))
        else $error("tracking not cleared after frame result");

    // Tracked extremes stay ordered.
    a_left_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left_seen |-> (r_left_lo <= r_left_hi))
        else $error("left minimum above left maximum");

    a_right_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_right_seen |-> (r_right_lo <= r_right_hi))
        else $error("right minimum above right maximum");

endmodule

`default_nettype wire

// File: bench/lane_intercept_checker.sv
// Predicts the per-frame lane intercept reports of the classifier and compares them with the block.
`timescale 1ns / 1ps

module lane_intercept_checker
    import lsic_pkg::*;
#(
    parameter int RESULT_BITS = 20
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    input  wire logic                          i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  wire logic [COORD_W-1:0]            i_cfg_data,

    input  wire logic                          i_word_valid,
    input  wire logic                          i_word_ready,
    input  wire logic [COORD_W-1:0]            i_x_start,
    input  wire logic [COORD_W-1:0]            i_y_start,
    input  wire logic [COORD_W-1:0]            i_x_end,
    input  wire logic [COORD_W-1:0]            i_y_end,
    input  wire logic                          i_has_segment,
    input  wire logic                          i_last_of_frame,

    input  wire logic                          i_rep_valid,
    input  wire logic                          i_rep_ready,
    input  wire logic signed [RESULT_BITS-1:0] i_left_min_x,
    input  wire logic signed [RESULT_BITS-1:0] i_left_max_x,
    input  wire logic signed [RESULT_BITS-1:0] i_right_min_x,
    input  wire logic signed [RESULT_BITS-1:0] i_right_max_x,
    input  wire logic                          i_left_found,
    input  wire logic                          i_right_found,

    output int                                 o_mismatches,
    output int                                 o_reports_pending
);

    typedef struct {
        logic signed [RESULT_BITS-1:0] left_min;
        logic signed [RESULT_BITS-1:0] left_max;
        logic signed [RESULT_BITS-1:0] right_min;
        logic signed [RESULT_BITS-1:0] right_max;
        logic                          left_found;
        logic                          right_found;
    } t_frame_report;

    t_frame_report       report_q[$];
    logic [COORD_W-1:0]  ref_row;
    logic [SLOPE_W-1:0]  slope_cap;
    bit                  left_seen;
    bit                  right_seen;
    longint              left_lo;
    longint              left_hi;
    longint              right_lo;
    longint              right_hi;
    int                  faults = 0;
    int                  queued = 0;
    int                  reports_seen = 0;

    assign o_mismatches      = faults;
    assign o_reports_pending = queued;

    task automatic log_fault(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        faults++;
    endtask

    task automatic check_field(input string name, input logic [RESULT_BITS-1:0] got,
                               input logic [RESULT_BITS-1:0] want);
        if (got !== want) begin
            log_fault($sformatf("report %0d %s: got %0d, expected %0d",
                                reports_seen, name, $signed(got), $signed(want)));
        end
    endtask

    function automatic longint clip_to_result(input longint v);
        longint hi_lim;
        hi_lim = (longint'(1) <<< (RESULT_BITS - 1)) - 1;
        if (v > hi_lim) return hi_lim;
        if (v < -hi_lim - 1) return -hi_lim - 1;
        return v;
    endfunction

    task automatic clear_frame();
        left_seen  = 1'b0;
        right_seen = 1'b0;
        left_lo    = 0;
        left_hi    = 0;
        right_lo   = 0;
        right_hi   = 0;
    endtask

    task automatic note_intercept(inout bit seen, inout longint lo, inout longint hi,
                                  input longint x);
        if (!seen) begin
            seen = 1'b1;
            lo   = x;
            hi   = x;
        end else begin
            if (x < lo) lo = x;
            if (x > hi) hi = x;
        end
    endtask

    // Classifies one accepted word and, on the last word of a frame, queues the report.
    task automatic absorb_word();
        longint        xs, ys, xe, ye, yr;
        longint        dx, dy, adx, ady, lim, x_at_row;
        t_frame_report rep;
        xs  = longint'(i_x_start);
        ys  = longint'(i_y_start);
        xe  = longint'(i_x_end);
        ye  = longint'(i_y_end);
        yr  = longint'(ref_row);
        lim = longint'(slope_cap);
        if (i_has_segment) begin
            dx  = xe - xs;
            dy  = ye - ys;
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            // A slope exactly on the limit only passes when the segment runs to the right.
            if (dy != 0 && (ady < lim * adx || (dx > 0 && ady == lim * dx))) begin
                x_at_row = clip_to_result(((yr - ys) * dx + xs * dy) / dy);
                if ((dx < 0) != (dy < 0)) begin
                    note_intercept(left_seen, left_lo, left_hi, x_at_row);
                end else begin
                    note_intercept(right_seen, right_lo, right_hi, x_at_row);
                end
            end
        end
        if (i_last_of_frame) begin
            // Extremes of an empty side are still zero from the last clear.
            rep.left_min    = left_lo[RESULT_BITS-1:0];
            rep.left_max    = left_hi[RESULT_BITS-1:0];
            rep.right_min   = right_lo[RESULT_BITS-1:0];
            rep.right_max   = right_hi[RESULT_BITS-1:0];
            rep.left_found  = left_seen;
            rep.right_found = right_seen;
            report_q.insert(report_q.size(), rep);
            clear_frame();
        end
    endtask

    task automatic compare_report();
        t_frame_report want;
        if (report_q.size() == 0) begin
            log_fault($sformatf("report %0d arrived with none expected", reports_seen));
        end else begin
            want = report_q.pop_front();
            check_field("left_min_x", i_left_min_x, want.left_min);
            check_field("left_max_x", i_left_max_x, want.left_max);
            check_field("right_min_x", i_right_min_x, want.right_min);
            check_field("right_max_x", i_right_max_x, want.right_max);
            check_field("left_found", RESULT_BITS'(i_left_found), RESULT_BITS'(want.left_found));
            check_field("right_found", RESULT_BITS'(i_right_found),
                        RESULT_BITS'(want.right_found));
        end
        reports_seen++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ref_row   = Y_REFERENCE_RST;
            slope_cap = SLOPE_LIMIT_RST;
            clear_frame();
            report_q.delete();
        end else begin
            if (i_rep_valid && i_rep_ready) begin
                compare_report();
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_Y_REFERENCE: ref_row = i_cfg_data;
                    CFG_SLOPE_LIMIT: slope_cap = i_cfg_data[SLOPE_W-1:0];
                    default: ;
                endcase
            end
            if (i_word_valid && i_word_ready) begin
                absorb_word();
            end
        end
        queued = report_q.size();
    end

endmodule

// File: bench/testbench.sv
// Top of the lane segment intercept classifier bench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import lsic_pkg::*;

    localparam int RES_W       = 20;
    localparam int CLK_PERIOD  = 8;
    // Bits of the slope write above the slope field.
    localparam int JUNK_W      = COORD_W - SLOPE_W;
    // The settle wait after a drain covers a word that is still in the divider plus a
    // receiver stall.
    localparam int SETTLE      = 60;
    // Long enough that a second frame end arrives while the first report waits.
    localparam int LONG_HOLD   = 700;
    // The limit leaves a wide margin over roughly 1300 words plus stalls and drains.
    localparam int CYCLE_LIMIT = 500000;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_idx = CFG_Y_REFERENCE;
    logic [COORD_W-1:0]      cfg_data = '0;
    logic                    word_valid = 1'b0;
    logic                    word_ready;
    logic [COORD_W-1:0]      x_start = '0;
    logic [COORD_W-1:0]      y_start = '0;
    logic [COORD_W-1:0]      x_end = '0;
    logic [COORD_W-1:0]      y_end = '0;
    logic                    has_segment = 1'b0;
    logic                    last_of_frame = 1'b0;
    logic                    rep_valid;
    logic                    rep_ready = 1'b0;
    logic signed [RES_W-1:0] left_min_x;
    logic signed [RES_W-1:0] left_max_x;
    logic signed [RES_W-1:0] right_min_x;
    logic signed [RES_W-1:0] right_max_x;
    logic                    left_found;
    logic                    right_found;

    int                      mismatches;
    int                      reports_pending;
    int                      cycle_count = 0;
    int                      words_sent = 0;
    int                      frames_sent = 0;
    int                      settings_used = 0;
    logic [SLOPE_W-1:0]      cur_slope = SLOPE_LIMIT_RST;
    // Set by the stimulus to ask the report sink for one long hold-off.
    bit                      hold_wanted = 1'b0;
    // Once set, neither side idles any more.
    bit                      calm = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    lane_segment_intercept_classifier_top #(
        .RESULT_BITS(RES_W)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_valid        (word_valid),
        .o_ready        (word_ready),
        .i_x_start      (x_start),
        .i_y_start      (y_start),
        .i_x_end        (x_end),
        .i_y_end        (y_end),
        .i_has_segment  (has_segment),
        .i_last_of_frame(last_of_frame),
        .o_valid        (rep_valid),
        .i_ready        (rep_ready),
        .o_left_min_x   (left_min_x),
        .o_left_max_x   (left_max_x),
        .o_right_min_x  (right_min_x),
        .o_right_max_x  (right_max_x),
        .o_left_found   (left_found),
        .o_right_found  (right_found)
    );

    // The checker sits beside the block, sees both channels and the register port,
    // and reports how many mismatches it found and how many reports are still owed.
    lane_intercept_checker #(
        .RESULT_BITS(RES_W)
    ) u_intercept_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data),
        .i_word_valid     (word_valid),
        .i_word_ready     (word_ready),
        .i_x_start        (x_start),
        .i_y_start        (y_start),
        .i_x_end          (x_end),
        .i_y_end          (y_end),
        .i_has_segment    (has_segment),
        .i_last_of_frame  (last_of_frame),
        .i_rep_valid      (rep_valid),
        .i_rep_ready      (rep_ready),
        .i_left_min_x     (left_min_x),
        .i_left_max_x     (left_max_x),
        .i_right_min_x    (right_min_x),
        .i_right_max_x    (right_max_x),
        .i_left_found     (left_found),
        .i_right_found    (right_found),
        .o_mismatches     (mismatches),
        .o_reports_pending(reports_pending)
    );

    // Watchdog: a run that never finishes its drain ends here as a failure.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d reports outstanding",
                     cycle_count, reports_pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Report sink. It mixes ready stretches with stall bursts, and serves one
    // long hold-off when the stimulus asks for it. Every pass drives ready once and
    // then waits at least one edge, so ready never gets two updates in one step.
    initial begin : report_sink
        wait (rst_n === 1'b1);
        forever begin
            if (hold_wanted) begin
                hold_wanted = 1'b0;
                rep_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                rep_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end else begin
                rep_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    // Offers one word and returns after the edge that accepts it. Valid stays high on
    // return, so a word that follows at once keeps valid up without a dip. A random
    // sender gap lowers valid first, which also puts gaps on every phase of the block.
    task automatic offer_word(input logic [COORD_W-1:0] xs, input logic [COORD_W-1:0] ys,
                              input logic [COORD_W-1:0] xe, input logic [COORD_W-1:0] ye,
                              input logic has, input logic last);
        if (!calm && $urandom_range(0, 7) == 0) begin
            word_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        word_valid    <= 1'b1;
        x_start       <= xs;
        y_start       <= ys;
        x_end         <= xe;
        y_end         <= ye;
        has_segment   <= has;
        last_of_frame <= last;
        @(posedge clk);
        while (!word_ready) @(posedge clk);
        if (has || last) words_sent++;
        if (last) frames_sent++;
    endtask

    // Stops offering and waits until every owed report has come back, then lets a
    // segment that is still in the divider finish before anything else happens.
    task automatic drain_reports();
        word_valid <= 1'b0;
        @(posedge clk);
        @(posedge clk);
        while (reports_pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Writes both registers on back-to-back edges. The upper data bits of the slope
    // write are junk that the block has to ignore.
    task automatic set_config(input logic [COORD_W-1:0] row, input logic [SLOPE_W-1:0] slope);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_Y_REFERENCE;
        cfg_data <= row;
        @(posedge clk);
        cfg_idx  <= CFG_SLOPE_LIMIT;
        cfg_data <= {JUNK_W'($urandom_range(0, 63)), slope};
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_slope = slope;
        settings_used++;
    endtask

    function automatic logic [COORD_W-1:0] pin_coord(input int v);
        if (v < 0) return '0;
        if (v > 1023) return COORD_W'(1023);
        return COORD_W'(v);
    endfunction

    // Mostly lane-like segments near or inside the slope limit, with some fully
    // random endpoints, segments exactly on the limit, degenerate and tiny ones.
    task automatic random_segment(output logic [COORD_W-1:0] xs, output logic [COORD_W-1:0] ys,
                                  output logic [COORD_W-1:0] xe, output logic [COORD_W-1:0] ye);
        int kind;
        int ax;
        int ay;
        int lim;
        int shape;
        xs    = COORD_W'($urandom_range(0, 1023));
        ys    = COORD_W'($urandom_range(0, 1023));
        kind  = $urandom_range(0, 9);
        lim   = (cur_slope == 0) ? 1 : int'(cur_slope);
        ax    = 0;
        ay    = 0;
        shape = $urandom_range(0, 2);
        if (kind <= 1) begin
            xe = COORD_W'($urandom_range(0, 1023));
            ye = COORD_W'($urandom_range(0, 1023));
            return;
        end else if (kind <= 6) begin
            ax = $urandom_range(1, 400);
            ay = $urandom_range(0, ax * lim + 1);
        end else if (kind == 7) begin
            ax = $urandom_range(1, 60);
            ay = ax * int'(cur_slope);
        end else if (kind == 8) begin
            // Vertical, horizontal or a single point.
            if (shape == 0) ay = $urandom_range(1, 500);
            else if (shape == 1) ax = $urandom_range(1, 500);
        end else begin
            ax = $urandom_range(0, 3);
            ay = $urandom_range(0, 3);
        end
        if ($urandom_range(0, 1) == 1) ax = -ax;
        if ($urandom_range(0, 1) == 1) ay = -ay;
        xe = pin_coord(int'(xs) + ax);
        ye = pin_coord(int'(ys) + ay);
    endtask

    // One frame of random segments. Now and then an ignored marker is slipped in.
    // The frame is closed either by its final segment or by a bare marker.
    task automatic send_random_frame(input int longest);
        int                 count;
        int                 pick;
        bit                 seg_closes;
        logic [COORD_W-1:0] xs, ys, xe, ye;
        pick       = $urandom_range(0, 19);
        seg_closes = ($urandom_range(0, 9) < 7);
        if (pick == 0) count = 0;
        else if (pick == 1) count = $urandom_range(1, longest);
        else count = $urandom_range(1, (longest < 6) ? longest : 6);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 11) == 0) begin
                offer_word(COORD_W'($urandom_range(0, 1023)), COORD_W'($urandom_range(0, 1023)),
                           COORD_W'($urandom_range(0, 1023)), COORD_W'($urandom_range(0, 1023)),
                           1'b0, 1'b0);
            end
            random_segment(xs, ys, xe, ye);
            offer_word(xs, ys, xe, ye, 1'b1, (k == count - 1) && seg_closes);
        end
        if (count == 0 || !seg_closes) begin
            offer_word(COORD_W'($urandom_range(0, 1023)), COORD_W'($urandom_range(0, 1023)),
                       COORD_W'($urandom_range(0, 1023)), COORD_W'($urandom_range(0, 1023)),
                       1'b0, 1'b1);
        end
    endtask

    initial begin : stimulus
        int target;
        int budget;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the reset settings: reference row 400, slope limit 5.
        offer_word(0, 0, 1023, 1023, 1'b1, 1'b0);        // full diagonal, right side
        offer_word(1023, 0, 0, 1023, 1'b1, 1'b0);        // full anti-diagonal, left side
        offer_word(500, 100, 500, 900, 1'b1, 1'b0);      // vertical, never kept
        offer_word(300, 300, 300, 300, 1'b1, 1'b0);      // a single point
        offer_word(0, 500, 1023, 500, 1'b1, 1'b0);       // horizontal, kept but dropped
        offer_word(100, 100, 101, 105, 1'b1, 1'b0);      // exactly on the limit, rightward
        offer_word(101, 105, 100, 100, 1'b1, 1'b0);      // on the limit but leftward
        offer_word(100, 105, 101, 100, 1'b1, 1'b0);      // on the limit, falling, left side
        offer_word(100, 100, 101, 106, 1'b1, 1'b0);      // just past the limit
        offer_word(0, 1023, 1023, 1022, 1'b1, 1'b0);     // intercept saturates high
        offer_word(1023, 1023, 0, 1022, 1'b1, 1'b1);     // saturates low, closes the frame
        offer_word(0, 0, 0, 0, 1'b0, 1'b1);              // empty frame from a bare marker
        offer_word(1023, 1023, 1023, 1023, 1'b0, 1'b0);  // ignored marker
        offer_word(512, 700, 600, 650, 1'b1, 1'b0);
        offer_word(1023, 1023, 1023, 1023, 1'b0, 1'b1);  // bare marker closes one segment
        drain_reports();

        // Steepest limit with the reference row at the bottom of the image.
        set_config(1023, 15);
        offer_word(0, 0, 1, 15, 1'b1, 1'b0);             // on the limit at fifteen
        offer_word(0, 0, 1, 16, 1'b1, 1'b0);             // one past it
        offer_word(1023, 0, 1021, 15, 1'b1, 1'b1);       // steep left segment, last
        drain_reports();

        // Random part, one register setting per phase. The slope-zero phase is short
        // since it rejects every segment; the final phase runs without idling.
        for (int phase = 0; phase < 7; phase++) begin
            budget = 180;
            case (phase)
                0: set_config(0, 1);
                1: set_config(1023, 15);
                2: set_config(0, 15);
                3: set_config(1023, 1);
                4: begin
                    set_config(COORD_W'($urandom_range(0, 1023)), 0);
                    budget = 40;
                end
                5: set_config(COORD_W'($urandom_range(0, 1023)), SLOPE_W'($urandom_range(1, 15)));
                default: begin
                    calm = 1'b1;
                    budget = 200;
                    set_config(COORD_W'($urandom_range(0, 1023)),
                               SLOPE_W'($urandom_range(1, 15)));
                end
            endcase
            target = words_sent + budget;
            if (phase == 1) begin
                // Short frames while the sink holds off: the second frame end has to
                // wait behind an unread report, so the block stops taking words.
                hold_wanted = 1'b1;
                repeat (25) send_random_frame(2);
            end
            while (words_sent < target) begin
                send_random_frame(40);
                if (phase == 3 && words_sent >= target - budget / 2 && reports_pending > 0) begin
                    // Pause the sender late in the phase until every report is back.
                    drain_reports();
                    target = target + 1;
                end
            end
            drain_reports();
        end

        $display("Covered %0d segment and end-marker words in %0d frames over %0d settings,",
                 words_sent, frames_sent, settings_used);
        $display("reference rows 0 to 1023, slope limits 0 to 15, a long report stall "
                 , "and drains.");
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/lsic_pkg.sv
rtl/core/lsic_div.sv
rtl/core/lane_segment_intercept_classifier_top.sv
bench/lane_intercept_checker.sv
bench/testbench.sv
